// File: rtl/core/bitstream_reader_exp_golomb_defines.svh
// Assertion macros for the Exp-Golomb bitstream reader.
// Included by the top level; no other dependencies.
`ifndef BITSTREAM_READER_EXP_GOLOMB_DEFINES_SVH
`define BITSTREAM_READER_EXP_GOLOMB_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSEG_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bseg: same-cycle check failed");
// next-cycle implication
`define BSEG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bseg: next-cycle check failed");
`else
`define BSEG_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BSEG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/bseg_pkg.sv
// Shared types and constants for the Exp-Golomb bitstream reader.
// No dependencies; imported by every module of the block but bseg_ram.
`timescale 1ns / 1ps

package bseg_pkg;

   localparam int BUF_BYTES_DEF = 4096;
   localparam int CFG_W         = 13;
   localparam int POS_W         = 16;
   localparam int KIND_W        = 3;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = 7;
   localparam int VALUE_W       = 64;
   localparam int GOLOMB_W      = 33;
   localparam int CODE_W        = 32;
   localparam int ZERO_W        = 5;
   localparam int MAX_BITS      = 64;
   localparam int ZERO_LIMIT    = 32;
   localparam int SIZE_CAP      = 8191;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 120;
   localparam int RSP_USER_W    = 1;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 3'd0,
      KIND_PEEK    = 3'd1,
      KIND_READ    = 3'd2,
      KIND_UE      = 3'd3,
      KIND_SE      = 3'd4,
      KIND_TE      = 3'd5,
      KIND_RESTART = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_BITS,
      ST_PREFIX,
      ST_SUFCHK,
      ST_SUFFIX,
      ST_POST,
      ST_TEBIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  byte_value;
      logic [CNT_W-1:0]   bit_count;
   } item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]         value;
      logic signed [GOLOMB_W-1:0] golomb_value;
      logic                       error;
      logic [POS_W-1:0]           bit_position;
   } result_type;

endpackage

// File: rtl/core/bitstream_reader_exp_golomb.sv
// Top level of the Exp-Golomb bitstream reader: size register, engine, output.
// Depends on bseg_pkg, bseg_engine, bseg_rsp_reg and the defines header.
`timescale 1ns / 1ps
`include "bitstream_reader_exp_golomb_defines.svh"

// Usage
//   req channel: one item per command. req_tuser carries the kind (load,
//   peek, read, ue, se, te, restart); req_tdata carries the load byte and the
//   bit count. Every item yields exactly one item on the rsp channel with the
//   bits read, the decoded Golomb value, the sticky error flag and the new
//   bit position.
//   csr port: a write sets the valid buffer size in bytes. Write only while
//   the block is idle.
//   Timing: bits are pulled from the byte store one per cycle, set by the
//   single registered read port and the one-bit cursor. A load, restart or
//   rejected read pulls no bits, a peek or read of n bits pulls n, a ue/se
//   decode with z leading zeros pulls z+1 prefix bits and z suffix bits, te
//   one bit more when the code number is 1. The result goes to rsp through
//   the output register; the next item is taken once the engine is idle again.
//   Reset: position, error flag and load pointer clear, the size register
//   returns to 4096; the byte store is not cleared, so no clearing pass.
//   Stall: a result waits in the output register; the engine finishes its
//   next item and then holds until the register frees up.
module bitstream_reader_exp_golomb #(
   parameter int BUF_BYTES = bseg_pkg::BUF_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: buffer_size_bytes
   input  logic                              csr_wr_en,
   input  logic [bseg_pkg::CFG_W-1:0]        csr_wr_data,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bseg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] byte_value, [14:8] bit_count
   input  logic [bseg_pkg::KIND_W-1:0]       req_tuser,   // [2:0] kind
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] value, [96:64] golomb_value, [112:97] bit_position
   output logic [bseg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [bseg_pkg::RSP_USER_W-1:0]   rsp_tuser    // [0] error
);
   import bseg_pkg::*;

   // reads never go past the store itself nor past what the register allows
   localparam int SIZE_LIM = (BUF_BYTES > SIZE_CAP) ? SIZE_CAP : BUF_BYTES;

   logic [CFG_W-1:0] size_ff, size_in;
   logic [CFG_W-1:0] lim_bytes;
   logic [POS_W-1:0] limit_bits;
   item_type         item;
   result_type       eng_res;
   logic             eng_res_valid;
   logic             eng_res_ready;

   // hold the size register; take a write whenever the enable is high
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         size_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CFG_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign lim_bytes  = (size_ff > CFG_W'(SIZE_LIM)) ? CFG_W'(SIZE_LIM) : size_ff;
   assign limit_bits = {lim_bytes, 3'b000};

   // unpack the request item
   assign item.kind       = kind_type'(req_tuser);
   assign item.byte_value = req_tdata[BYTE_W-1:0];
   assign item.bit_count  = req_tdata[BYTE_W +: CNT_W];

   bseg_engine #(
      .BUF_BYTES (BUF_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .limit_bits (limit_bits),
      .res_valid  (eng_res_valid),
      .res_ready  (eng_res_ready),
      .res        (eng_res)
   );

   bseg_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (eng_res_valid),
      .in_ready   (eng_res_ready),
      .res        (eng_res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // one item in flight: an accepted item blocks the next one until its result is handed off
   `BSEG_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // a finished result and a new item are never both pending at the engine
   `BSEG_ASSERT_IMPLY(a_res_excl, clock, reset, eng_res_valid, !req_tready)
   // nothing shows on the response side right after reset
   `BSEG_ASSERT_IMPLY(a_rst_quiet, clock, 1'b0, $past(reset), !rsp_tvalid)

endmodule

// File: rtl/core/bseg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the byte store.
`timescale 1ns / 1ps

module bseg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bseg_engine.sv
// Bit-serial sequencer: byte store, read cursor and Exp-Golomb decoder.
// Depends on bseg_pkg and bseg_ram.
`timescale 1ns / 1ps

module bseg_engine #(
   parameter int BUF_BYTES = bseg_pkg::BUF_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   output logic                        item_ready,
   input  bseg_pkg::item_type          item,
   input  logic [bseg_pkg::POS_W-1:0]  limit_bits,
   output logic                        res_valid,
   input  logic                        res_ready,
   output bseg_pkg::result_type        res
);
   import bseg_pkg::*;

   localparam int AW   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int LP_W = $clog2(BUF_BYTES + 1);

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    cur_ff, cur_in;
   logic                err_ff, err_in;
   logic [LP_W-1:0]     lp_ff, lp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ZERO_W-1:0]   zeros_ff, zeros_in;
   logic [CODE_W-1:0]   acc_ff, acc_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic signed [GOLOMB_W-1:0] golomb_ff, golomb_in;

   logic              wr_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              bit_now;
   logic              at_end;
   logic              rd_bad;
   logic              suf_over;
   logic              is_decode;
   logic              advance;
   logic [POS_W-1:0]  pos_fin;
   logic              handoff;
   logic              load_ok;
   logic [CODE_W-2:0] se_mag;

   // read address follows the next cursor, so the registered byte always
   // matches the current cursor
   assign rd_addr = AW'(cur_in >> 3);

   bseg_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(lp_ff)),
      .wr_data (item_ff.byte_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign bit_now   = rd_data[~cur_ff[2:0]];
   assign at_end    = (cur_ff >= limit_bits);
   assign rd_bad    = (item_ff.bit_count == '0) ||
                      (item_ff.bit_count > CNT_W'(MAX_BITS)) ||
                      (({1'b0, pos_ff} + (POS_W+1)'(item_ff.bit_count)) >
                       {1'b0, limit_bits});
   assign suf_over  = ({1'b0, cur_ff} + (POS_W+1)'(zeros_ff)) > {1'b0, limit_bits};
   assign is_decode = (item_ff.kind == KIND_UE) || (item_ff.kind == KIND_SE) ||
                      (item_ff.kind == KIND_TE);
   assign advance   = ((item_ff.kind == KIND_READ) && !err_ff) || is_decode;
   assign pos_fin   = advance ? cur_ff : pos_ff;
   assign handoff   = res_valid && res_ready;
   assign load_ok   = (lp_ff < LP_W'(BUF_BYTES));
   assign se_mag    = acc_ff[CODE_W-1:1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            priority case (item_ff.kind)
               KIND_PEEK, KIND_READ: state_in = rd_bad ? ST_DONE : ST_BITS;
               KIND_UE, KIND_SE, KIND_TE: state_in = err_ff ? ST_DONE : ST_PREFIX;
               default: state_in = ST_DONE;
            endcase
         end
         ST_BITS: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_PREFIX: begin
            priority if (at_end) begin
               state_in = ST_DONE;
            end else if (bit_now) begin
               state_in = (zeros_ff == '0) ? ST_POST : ST_SUFCHK;
            end else if (zeros_ff == ZERO_W'(ZERO_LIMIT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SUFCHK: state_in = suf_over ? ST_DONE : ST_SUFFIX;
         ST_SUFFIX: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if ((item_ff.kind == KIND_TE) && (acc_ff == CODE_W'(2))) begin
               state_in = ST_TEBIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TEBIT: state_in = ST_DONE;
         ST_DONE: begin
            if (handoff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      item_in   = item_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      err_in    = err_ff;
      lp_in     = lp_ff;
      cnt_in    = cnt_ff;
      zeros_in  = zeros_ff;
      acc_in    = acc_ff;
      value_in  = value_ff;
      golomb_in = golomb_ff;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: item_in = item;
         ST_START: begin
            cur_in    = pos_ff;
            value_in  = '0;
            golomb_in = '0;
            zeros_in  = '0;
            cnt_in    = item_ff.bit_count;
            priority case (item_ff.kind)
               KIND_LOAD: begin
                  if (load_ok) begin
                     wr_en = 1'b1;
                     lp_in = lp_ff + LP_W'(1);
                  end
               end
               KIND_PEEK, KIND_READ: begin
                  if (rd_bad) begin
                     err_in = 1'b1;
                  end
               end
               KIND_RESTART: begin
                  pos_in = '0;
                  cur_in = '0;
                  err_in = 1'b0;
               end
               default: ;
            endcase
         end
         ST_BITS: begin
            value_in = {value_ff[VALUE_W-2:0], bit_now};
            cur_in   = cur_ff + POS_W'(1);
            cnt_in   = cnt_ff - CNT_W'(1);
         end
         ST_PREFIX: begin
            if (at_end) begin
               err_in = 1'b1;
            end else begin
               cur_in = cur_ff + POS_W'(1);
               if (bit_now) begin
                  acc_in = CODE_W'(1);
               end else begin
                  zeros_in = zeros_ff + ZERO_W'(1);
                  if (zeros_ff == ZERO_W'(ZERO_LIMIT - 1)) begin
                     err_in = 1'b1;
                  end
               end
            end
         end
         ST_SUFCHK: begin
            if (suf_over) begin
               err_in = 1'b1;
            end
            cnt_in = CNT_W'(zeros_ff);
         end
         ST_SUFFIX: begin
            acc_in = {acc_ff[CODE_W-2:0], bit_now};
            cur_in = cur_ff + POS_W'(1);
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_POST: begin
            // acc holds code number plus one
            priority case (item_ff.kind)
               KIND_SE: begin
                  if (acc_ff[0]) begin
                     golomb_in = GOLOMB_W'(0) - {2'b00, se_mag};
                  end else begin
                     golomb_in = {2'b00, se_mag};
                  end
               end
               KIND_TE: begin
                  if (acc_ff != CODE_W'(2)) begin
                     golomb_in = {1'b0, acc_ff - CODE_W'(1)};
                  end
               end
               default: golomb_in = {1'b0, acc_ff - CODE_W'(1)};
            endcase
         end
         ST_TEBIT: begin
            if (at_end) begin
               err_in = 1'b1;
            end else begin
               golomb_in = {{(GOLOMB_W-1){1'b0}}, ~bit_now};
               cur_in    = cur_ff + POS_W'(1);
            end
         end
         ST_DONE: begin
            if (handoff) begin
               pos_in = pos_fin;
               cur_in = pos_fin;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         cur_ff   <= '0;
         err_ff   <= 1'b0;
         lp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cur_ff   <= cur_in;
         err_ff   <= err_in;
         lp_ff    <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      cnt_ff    <= cnt_in;
      zeros_ff  <= zeros_in;
      acc_ff    <= acc_in;
      value_ff  <= value_in;
      golomb_ff <= golomb_in;
   end

   assign item_ready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_DONE);
   assign res.value        = value_ff;
   assign res.golomb_value = golomb_ff;
   assign res.error        = err_ff;
   assign res.bit_position = pos_fin;

endmodule

// File: rtl/core/bseg_rsp_reg.sv
// Output register for result items; packs a result onto the stream bus.
// Depends on bseg_pkg.
`timescale 1ns / 1ps

module bseg_rsp_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  bseg_pkg::result_type              res,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bseg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [bseg_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import bseg_pkg::*;

   localparam int PAD_W = RSP_DATA_W - VALUE_W - GOLOMB_W - POS_W;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, data_ff.bit_position, data_ff.golomb_value,
                        data_ff.value};
   assign rsp_tuser  = data_ff.error;

endmodule

// File: dv/bseg_scoreboard.sv
// Scoreboard for the Exp-Golomb bitstream reader: predicts and checks each result item.
// Depends on bseg_pkg; watches the csr, req and rsp channels of the block.
`timescale 1ns / 1ps

module bseg_scoreboard
   import bseg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic [KIND_W-1:0]       req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [RSP_USER_W-1:0]   rsp_tuser,
   output int                      fail_count,
   output int                      expected_left
);

   localparam int STORE_BYTES = BUF_BYTES_DEF;
   localparam int REPORT_MAX  = 10;

   logic [BYTE_W-1:0] mem_bytes [STORE_BYTES];
   int unsigned       load_ptr;
   int unsigned       bit_pos;
   logic              sticky_err;
   logic [CFG_W-1:0]  size_reg;
   result_type        expected_q [$];
   int                result_num;

   // Bits at the cursor, MSB first; flag a bad count or an overrun.
   function automatic logic [VALUE_W-1:0] peek_stream(int unsigned n);
      int unsigned         limit;
      int unsigned         p;
      logic [VALUE_W-1:0]  v;
      limit = ((size_reg > STORE_BYTES) ? STORE_BYTES : int'(size_reg)) * 8;
      v = '0;
      if (n == 0 || n > MAX_BITS || bit_pos + n > limit) begin
         sticky_err = 1'b1;
         return '0;
      end
      for (int i = 0; i < n; i++) begin
         p = bit_pos + i;
         v = {v[VALUE_W-2:0], mem_bytes[p >> 3][7 - (p & 7)]};
      end
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] pull_stream(int unsigned n);
      logic [VALUE_W-1:0] v;
      v = peek_stream(n);
      if (!sticky_err)
         bit_pos += n;
      return v;
   endfunction

   // Code number of one Exp-Golomb code; 0 on failure.
   function automatic logic decode_code_number(output logic [CODE_W-1:0] code);
      int unsigned         zeros;
      logic [VALUE_W-1:0]  b;
      logic [VALUE_W-1:0]  suffix;
      zeros  = 0;
      suffix = '0;
      code   = '0;
      b = pull_stream(1);
      while (!sticky_err && b[0] == 1'b0) begin
         zeros++;
         if (zeros > 31) begin
            sticky_err = 1'b1;
            return 1'b0;
         end
         b = pull_stream(1);
      end
      if (sticky_err)
         return 1'b0;
      if (zeros > 0) begin
         suffix = pull_stream(zeros);
         if (sticky_err)
            return 1'b0;
      end
      code = CODE_W'(((64'd1 << zeros) - 64'd1) + suffix);
      return 1'b1;
   endfunction

   function automatic result_type predict_result(logic [KIND_W-1:0] kind,
                                                 logic [BYTE_W-1:0] byte_in,
                                                 logic [CNT_W-1:0] count);
      result_type           r;
      logic [CODE_W-1:0]    code;
      logic [GOLOMB_W-1:0]  g;
      logic [VALUE_W-1:0]   b;
      logic [VALUE_W-1:0]   mag;
      r = '0;
      g = '0;
      case (kind)
         KIND_LOAD: begin
            if (load_ptr < STORE_BYTES) begin
               mem_bytes[load_ptr] = byte_in;
               load_ptr++;
            end
         end
         KIND_PEEK: r.value = peek_stream(count);
         KIND_READ: r.value = pull_stream(count);
         KIND_UE: begin
            if (decode_code_number(code))
               g = {1'b0, code};
         end
         KIND_SE: begin
            if (decode_code_number(code)) begin
               mag = ({32'd0, code} + 64'd1) >> 1;
               g = code[0] ? mag[GOLOMB_W-1:0] : (33'd0 - mag[GOLOMB_W-1:0]);
            end
         end
         KIND_TE: begin
            if (decode_code_number(code)) begin
               if (code != 32'd1) begin
                  g = {1'b0, code};
               end else begin
                  // truncated range: one inverted bit decides 0 or 1
                  b = pull_stream(1);
                  if (!sticky_err)
                     g = b[0] ? 33'd0 : 33'd1;
               end
            end
         end
         KIND_RESTART: begin
            bit_pos    = 0;
            sticky_err = 1'b0;
         end
         default: ;
      endcase
      r.golomb_value = g;
      r.error        = sticky_err;
      r.bit_position = POS_W'(bit_pos);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type exp_r;
      result_type act_r;
      if (reset) begin
         load_ptr   = 0;
         bit_pos    = 0;
         sticky_err = 1'b0;
         size_reg   = CFG_RESET;
         result_num = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (csr_wr_en)
            size_reg = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_result(req_tuser, req_tdata[7:0], req_tdata[14:8]));
         if (rsp_tvalid && rsp_tready) begin
            act_r.value        = rsp_tdata[63:0];
            act_r.golomb_value = rsp_tdata[96:64];
            act_r.bit_position = rsp_tdata[112:97];
            act_r.error        = rsp_tuser[0];
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("result %0d arrived with nothing expected", result_num);
            end else begin
               exp_r = expected_q.pop_front();
               if (act_r.value !== exp_r.value || act_r.golomb_value !== exp_r.golomb_value ||
                   act_r.error !== exp_r.error || act_r.bit_position !== exp_r.bit_position) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("result %0d: exp value %h golomb %h err %b pos %0d, got value %h golomb %h err %b pos %0d",
                              result_num, exp_r.value, exp_r.golomb_value, exp_r.error,
                              exp_r.bit_position, act_r.value, act_r.golomb_value,
                              act_r.error, act_r.bit_position);
               end
            end
            result_num++;
         end
      end
      expected_left = expected_q.size();
   end

endmodule

// File: dv/tb_bitstream_reader_exp_golomb.sv
// Testbench top for the Exp-Golomb bitstream reader: clock, reset, stimulus, verdict.
// Depends on bseg_pkg, bitstream_reader_exp_golomb and bseg_scoreboard.
`timescale 1ns / 1ps

module tb_bitstream_reader_exp_golomb;
   import bseg_pkg::*;

   localparam int               STORE_BYTES   = BUF_BYTES_DEF;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 3'd7;
   // the limit covers the longest item; stalls and gaps come on top
   localparam int               QUIET_LIMIT   = 3000;
   localparam int               SETTLE_CYCLES = 6;
   localparam int               DRAIN_CYCLES  = 80;
   localparam int               RAND_PHASES   = 10;
   localparam int               PHASE_ITEMS   = 38;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CFG_W-1:0]        csr_wr_data;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;     // [7:0] byte_value, [14:8] bit_count, [15] zero
   logic [KIND_W-1:0]       req_tuser;     // [2:0] kind
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [63:0] value, [96:64] golomb_value, [112:97] bit_position
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;     // [0] error

   int fail_count;
   int expected_left;
   int sender_pct;     // chance in 100, per draw, that the sender idles
   int stall_pct;      // chance in 100, per draw, that the receiver stalls
   int loaded;         // bytes written into the store so far
   int quiet_cycles;

   bitstream_reader_exp_golomb u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   bseg_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver side: drop tready at random, at the rate of the current idle mode.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: end the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Idle modes: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly.
   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin sender_pct = 0;  stall_pct = 0;  end
         1: begin sender_pct = 58; stall_pct = 0;  end
         2: begin sender_pct = 0;  stall_pct = 58; end
         default: begin sender_pct = 13; stall_pct = 13; end
      endcase
   endtask

   // Present one item and hold it until the block takes it. Valid stays high
   // on return so a back-to-back item follows without a bubble.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] byte_in,
                            input logic [CNT_W-1:0] count);
      while ($urandom_range(99) < sender_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {1'b0, count, byte_in};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (kind == KIND_LOAD && loaded < STORE_BYTES)
         loaded++;
      @(negedge clock);
   endtask

   // Write the size register only once every result is back and the engine is quiet.
   task automatic write_size(input logic [CFG_W-1:0] size_bytes);
      req_tvalid = 1'b0;
      while (expected_left != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = size_bytes;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly sane counts, with a share of full 64, zero and oversized ones.
   function automatic logic [CNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return CNT_W'($urandom_range(127, 65));
      else if (r < 11)
         return '0;
      else if (r < 24)
         return CNT_W'(MAX_BITS);
      else
         return CNT_W'($urandom_range(63, 1));
   endfunction

   // One random item; small byte values make long zero prefixes likely.
   task automatic send_random_op();
      int                r;
      logic [BYTE_W-1:0] data;
      r    = $urandom_range(99);
      data = ($urandom_range(1) == 1) ? BYTE_W'($urandom_range(255))
                                      : BYTE_W'($urandom_range(15));
      if (r < 14)
         send_item(KIND_LOAD, data, pick_count());
      else if (r < 26)
         send_item(KIND_PEEK, data, pick_count());
      else if (r < 46)
         send_item(KIND_READ, data, pick_count());
      else if (r < 61)
         send_item(KIND_UE, data, pick_count());
      else if (r < 74)
         send_item(KIND_SE, data, pick_count());
      else if (r < 88)
         send_item(KIND_TE, data, pick_count());
      else if (r < 97)
         send_item(KIND_RESTART, data, pick_count());
      else
         send_item(KIND_UNUSED, data, pick_count());
   endtask

   initial begin
      logic [BYTE_W-1:0] pattern [16];
      int                pick;

      // Directed stream: ue 0, se +1, se -1, te 1, te 0, te 2, then 38 zeros,
      // a run of ones and a final byte whose suffix runs off the end.
      pattern = '{8'hA6, 8'h8A, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      loaded      = 0;
      set_idle_mode(0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Nothing is loaded yet, so shrink the window to zero before any read.
      write_size('0);
      send_item(KIND_PEEK, 8'h00, 7'd8);        // size zero: every read overruns
      send_item(KIND_UNUSED, 8'hFF, 7'h7F);     // unused kind only reports state
      send_item(KIND_RESTART, 8'h00, 7'd0);
      for (int i = 0; i < 16; i++)
         send_item(KIND_LOAD, pattern[i], 7'd0);

      write_size(CFG_W'(16));
      send_item(KIND_UE, 8'h00, 7'd0);
      send_item(KIND_SE, 8'h00, 7'd0);
      send_item(KIND_SE, 8'h00, 7'd0);
      send_item(KIND_TE, 8'h00, 7'd0);
      send_item(KIND_TE, 8'h00, 7'd0);
      send_item(KIND_TE, 8'h00, 7'd0);
      send_item(KIND_UE, 8'h00, 7'd0);          // long zero prefix raises the flag
      send_item(KIND_PEEK, 8'h00, 7'd64);       // in-range peek while flagged
      send_item(KIND_READ, 8'h00, 7'd8);        // read while flagged: no advance
      send_item(KIND_RESTART, 8'h00, 7'd0);
      send_item(KIND_READ, 8'hFF, 7'd0);        // zero count
      send_item(KIND_RESTART, 8'h00, 7'd0);
      send_item(KIND_PEEK, 8'h00, 7'h7F);       // count over 64
      send_item(KIND_RESTART, 8'h00, 7'd0);
      send_item(KIND_READ, 8'h00, 7'd64);
      send_item(KIND_READ, 8'h00, 7'd56);
      send_item(KIND_UE, 8'h00, 7'd0);          // suffix runs past the end
      send_item(KIND_RESTART, 8'h00, 7'd0);
      send_item(KIND_READ, 8'h00, 7'd64);
      send_item(KIND_READ, 8'h00, 7'd64);
      send_item(KIND_SE, 8'h00, 7'd0);          // first prefix bit overruns
      send_item(KIND_RESTART, 8'h00, 7'd0);

      // Random phases. Keep the window inside the loaded bytes so no read
      // ever touches a byte that was never written.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         set_idle_mode(ph % 4);
         pick = $urandom_range(9);
         if (pick == 0)
            write_size('0);
         else if (pick < 4)
            write_size(CFG_W'(loaded));
         else if (pick < 5)
            write_size(CFG_W'(1));
         else
            write_size(CFG_W'($urandom_range(loaded, 1)));
         send_item(KIND_RESTART, 8'h00, 7'd0);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_op();
      end

      // Open the window to every loaded byte and walk to its very last bit.
      write_size(CFG_W'(loaded));
      set_idle_mode(2);
      send_item(KIND_RESTART, 8'h00, 7'd0);
      for (int i = 0; i < loaded / 8; i++)
         send_item(KIND_READ, 8'h00, 7'd64);
      if (loaded % 8 != 0)
         send_item(KIND_READ, 8'h00, CNT_W'((loaded % 8) * 8));
      send_item(KIND_READ, 8'h00, 7'd1);        // one bit past the end
      send_item(KIND_TE, 8'h00, 7'd0);          // decode while flagged
      send_item(KIND_RESTART, 8'h00, 7'd0);

      // Drain: wait for every result, then a quiet stretch for strays.
      req_tvalid = 1'b0;
      while (expected_left != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bseg_pkg.sv
rtl/core/bseg_ram.sv
rtl/core/bseg_engine.sv
rtl/core/bseg_rsp_reg.sv
rtl/core/bitstream_reader_exp_golomb.sv
dv/bseg_scoreboard.sv
dv/tb_bitstream_reader_exp_golomb.sv
